// ----- hw/rtl/cnw_pkg.sv -----
// ----------------------------------------------------------------------------
// cnw_pkg
// Shared types, constants and character tables for the cpio newc walker.
// ----------------------------------------------------------------------------
package cnw_pkg;

    // byte count within one stage; a stage can hold 2^32+2 bytes
    localparam int CNT_W = 34;

    localparam logic [6:0] HDR_LAST  = 7'd109;
    localparam logic [6:0] MAGIC_LEN = 7'd6;
    localparam logic [6:0] FS_FIRST  = 7'd54;
    localparam logic [6:0] FS_LAST   = 7'd61;
    localparam logic [6:0] NS_FIRST  = 7'd94;
    localparam logic [6:0] NS_LAST   = 7'd101;
    localparam logic [31:0] TRL_LEN  = 32'd11;

    localparam logic [2:0] ROLE_HEADER      = 3'd0;
    localparam logic [2:0] ROLE_NAME        = 3'd1;
    localparam logic [2:0] ROLE_NAME_PAD    = 3'd2;
    localparam logic [2:0] ROLE_CONTENT     = 3'd3;
    localparam logic [2:0] ROLE_CONTENT_PAD = 3'd4;
    localparam logic [2:0] ROLE_IGNORED     = 3'd5;

    localparam logic [1:0] STOP_RUNNING   = 2'd0;
    localparam logic [1:0] STOP_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STOP_TRAILER   = 2'd2;

    typedef enum logic [1:0] {
        STAGE_HEADER,
        STAGE_NAME,
        STAGE_CONTENT,
        STAGE_STOPPED
    } stage_t;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic        entry_ready;
        logic [31:0] file_length;
        logic [31:0] name_length;
        logic [31:0] content_offset;
        logic        is_trailer;
        logic [1:0]  stop_cause;
    } result_t;

    // ascii hex digit; anything else counts as zero
    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = c[3:0];
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            v = 4'(c[3:0] + 4'd9);
        end
        return v;
    endfunction

    // "070701"
    function automatic logic [7:0] magic_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0, 3'd2, 3'd4: c = 8'h30;
            3'd1, 3'd3:       c = 8'h37;
            3'd5:             c = 8'h31;
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

    // "TRAILER!!!" and its terminating zero
    function automatic logic [7:0] trailer_char(input logic [3:0] idx);
        logic [7:0] c;
        unique case (idx)
            4'd0:             c = 8'h54;
            4'd1:             c = 8'h52;
            4'd2:             c = 8'h41;
            4'd3:             c = 8'h49;
            4'd4:             c = 8'h4C;
            4'd5:             c = 8'h45;
            4'd6:             c = 8'h52;
            4'd7, 4'd8, 4'd9: c = 8'h21;
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ----- hw/rtl/cnw_parser.sv -----
// ----------------------------------------------------------------------------
// cnw_parser
// Per-byte parse state of the archive and the result for the current word.
// ----------------------------------------------------------------------------
module cnw_parser #(
    parameter int OFFSET_BITS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        data_byte,
    input  logic              archive_start,
    output cnw_pkg::result_t  result
);

    localparam int CW = cnw_pkg::CNT_W;

    cnw_pkg::stage_t         stage_reg, stage_next, stage_cur;
    logic [CW-1:0]           cnt_reg, cnt_next, cnt_cur, cnt_inc;
    logic [OFFSET_BITS-1:0]  off_reg, off_next, off_cur;
    logic [31:0]             fsize_reg, fsize_next, fsize_cur, fsize_b;
    logic [31:0]             nsize_reg, nsize_next, nsize_cur, nsize_b;
    logic [31:0]             acc_reg, acc_next, acc_cur, acc_b, acc_new;
    logic [31:0]             cstart_reg, cstart_next, cstart_cur, cstart_b;
    logic                    tmatch_reg, tmatch_next, tmatch_cur, tmatch_b, tmatch_new;
    logic [1:0]              stop_reg, stop_next, stop_cur;
    logic [CW-1:0]           ntotal_reg, ntotal_next, ntotal_cur;
    logic [CW-1:0]           ctotal_reg, ctotal_next, ctotal_cur;

    logic [6:0]              hdr_i;
    logic                    hdr_first, hdr_last, magic_bad, in_fs, in_ns, digit_first;
    logic                    name_done, content_done, content_empty, trl;
    logic [CW-1:0]           nround, ctot_calc;
    logic [63:0]             off_wide;

    // archive start restarts from the reset state before the byte is used
    assign stage_cur  = archive_start ? cnw_pkg::STAGE_HEADER : stage_reg;
    assign cnt_cur    = archive_start ? '0 : cnt_reg;
    assign off_cur    = archive_start ? '0 : off_reg;
    assign fsize_cur  = archive_start ? '0 : fsize_reg;
    assign nsize_cur  = archive_start ? '0 : nsize_reg;
    assign acc_cur    = archive_start ? '0 : acc_reg;
    assign cstart_cur = archive_start ? '0 : cstart_reg;
    assign tmatch_cur = archive_start ? 1'b1 : tmatch_reg;
    assign stop_cur   = archive_start ? cnw_pkg::STOP_RUNNING : stop_reg;
    assign ntotal_cur = archive_start ? '0 : ntotal_reg;
    assign ctotal_cur = archive_start ? '0 : ctotal_reg;

    assign cnt_inc   = cnt_cur + CW'(1);
    assign hdr_i     = cnt_cur[6:0];
    assign hdr_first = (hdr_i == 7'd0);
    assign hdr_last  = (hdr_i == cnw_pkg::HDR_LAST);
    assign magic_bad = (hdr_i < cnw_pkg::MAGIC_LEN)
                       && (data_byte != cnw_pkg::magic_char(hdr_i[2:0]));
    assign in_fs     = (hdr_i >= cnw_pkg::FS_FIRST) && (hdr_i <= cnw_pkg::FS_LAST);
    assign in_ns     = (hdr_i >= cnw_pkg::NS_FIRST) && (hdr_i <= cnw_pkg::NS_LAST);
    assign digit_first = (hdr_i == cnw_pkg::FS_FIRST) || (hdr_i == cnw_pkg::NS_FIRST);

    // new header clears the entry record
    assign fsize_b  = hdr_first ? '0 : fsize_cur;
    assign nsize_b  = hdr_first ? '0 : nsize_cur;
    assign acc_b    = hdr_first ? '0 : acc_cur;
    assign cstart_b = hdr_first ? '0 : cstart_cur;
    assign tmatch_b = hdr_first ? 1'b1 : tmatch_cur;
    assign acc_new  = {(digit_first ? 28'd0 : acc_b[27:0]),
                       cnw_pkg::hex_value(data_byte)};

    // name stage length: header plus name rounded up to four, minus header,
    // which works out to ((n + 1) & ~3) + 2
    assign nround    = CW'(nsize_cur) + CW'(1);
    assign ctot_calc = CW'(fsize_cur) + CW'(3);

    assign tmatch_new = tmatch_cur
                        && !((cnt_cur < CW'(cnw_pkg::TRL_LEN))
                             && (data_byte != cnw_pkg::trailer_char(cnt_cur[3:0])));
    assign name_done     = (cnt_inc == ntotal_cur);
    assign content_done  = (cnt_inc == ctotal_cur);
    assign content_empty = (ctotal_cur == '0);
    assign trl = name_done && tmatch_new && (nsize_cur >= cnw_pkg::TRL_LEN);

    assign off_next = off_cur + OFFSET_BITS'(1);
    assign off_wide = 64'(off_next);

    // next stage
    always_comb
    begin
        stage_next = stage_cur;
        unique case (stage_cur)
            cnw_pkg::STAGE_HEADER:
            begin
                if (magic_bad)
                begin
                    stage_next = cnw_pkg::STAGE_STOPPED;
                end
                else if (hdr_last)
                begin
                    stage_next = cnw_pkg::STAGE_NAME;
                end
            end
            cnw_pkg::STAGE_NAME:
            begin
                if (name_done)
                begin
                    if (trl)
                    begin
                        stage_next = cnw_pkg::STAGE_STOPPED;
                    end
                    else if (content_empty)
                    begin
                        stage_next = cnw_pkg::STAGE_HEADER;
                    end
                    else
                    begin
                        stage_next = cnw_pkg::STAGE_CONTENT;
                    end
                end
            end
            cnw_pkg::STAGE_CONTENT:
            begin
                if (content_done)
                begin
                    stage_next = cnw_pkg::STAGE_HEADER;
                end
            end
            cnw_pkg::STAGE_STOPPED:
            begin
                stage_next = cnw_pkg::STAGE_STOPPED;
            end
            default:
            begin
                stage_next = cnw_pkg::STAGE_STOPPED;
            end
        endcase
    end

    // datapath and result
    always_comb
    begin
        cnt_next    = cnt_cur;
        fsize_next  = fsize_cur;
        nsize_next  = nsize_cur;
        acc_next    = acc_cur;
        cstart_next = cstart_cur;
        tmatch_next = tmatch_cur;
        stop_next   = stop_cur;
        ntotal_next = ntotal_cur;
        ctotal_next = ctotal_cur;
        result      = '0;
        unique case (stage_cur)
            cnw_pkg::STAGE_HEADER:
            begin
                fsize_next  = fsize_b;
                nsize_next  = nsize_b;
                acc_next    = acc_b;
                cstart_next = cstart_b;
                tmatch_next = tmatch_b;
                if (magic_bad)
                begin
                    stop_next = cnw_pkg::STOP_BAD_MAGIC;
                end
                else
                begin
                    if (in_fs || in_ns)
                    begin
                        acc_next = acc_new;
                    end
                    if (hdr_i == cnw_pkg::FS_LAST)
                    begin
                        fsize_next = acc_new;
                    end
                    if (hdr_i == cnw_pkg::NS_LAST)
                    begin
                        nsize_next = acc_new;
                    end
                    cnt_next = hdr_last ? '0 : cnt_inc;
                    if (hdr_last)
                    begin
                        ntotal_next = {nround[CW-1:2], 2'b10};
                        ctotal_next = {ctot_calc[CW-1:2], 2'b00};
                    end
                end
                result.byte_role = cnw_pkg::ROLE_HEADER;
            end
            cnw_pkg::STAGE_NAME:
            begin
                tmatch_next = tmatch_new;
                cnt_next    = name_done ? '0 : cnt_inc;
                if (name_done)
                begin
                    cstart_next = off_wide[31:0];
                end
                if (trl)
                begin
                    stop_next = cnw_pkg::STOP_TRAILER;
                end
                result.byte_role   = (cnt_cur < CW'(nsize_cur)) ? cnw_pkg::ROLE_NAME
                                                                 : cnw_pkg::ROLE_NAME_PAD;
                result.entry_ready = name_done;
                result.is_trailer  = trl;
            end
            cnw_pkg::STAGE_CONTENT:
            begin
                cnt_next = content_done ? '0 : cnt_inc;
                result.byte_role = (cnt_cur < CW'(fsize_cur)) ? cnw_pkg::ROLE_CONTENT
                                                               : cnw_pkg::ROLE_CONTENT_PAD;
            end
            default:
            begin
                result.byte_role = cnw_pkg::ROLE_IGNORED;
            end
        endcase
        if (stage_cur != cnw_pkg::STAGE_STOPPED)
        begin
            result.file_length    = fsize_next;
            result.name_length    = nsize_next;
            result.content_offset = cstart_next;
        end
        result.stop_cause = stop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg  <= cnw_pkg::STAGE_HEADER;
            cnt_reg    <= '0;
            off_reg    <= '0;
            fsize_reg  <= '0;
            nsize_reg  <= '0;
            acc_reg    <= '0;
            cstart_reg <= '0;
            tmatch_reg <= 1'b1;
            stop_reg   <= cnw_pkg::STOP_RUNNING;
            ntotal_reg <= '0;
            ctotal_reg <= '0;
        end
        else if (step)
        begin
            stage_reg  <= stage_next;
            cnt_reg    <= cnt_next;
            off_reg    <= off_next;
            fsize_reg  <= fsize_next;
            nsize_reg  <= nsize_next;
            acc_reg    <= acc_next;
            cstart_reg <= cstart_next;
            tmatch_reg <= tmatch_next;
            stop_reg   <= stop_next;
            ntotal_reg <= ntotal_next;
            ctotal_reg <= ctotal_next;
        end
    end

endmodule

// ----- hw/rtl/cnw_out_buf.sv -----
// ----------------------------------------------------------------------------
// cnw_out_buf
// Two-entry result queue between the parser and the output channel.
// ----------------------------------------------------------------------------
module cnw_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cnw_pkg::result_t  push_data,
    output logic              full,
    output logic              head_valid,
    input  logic              pop_ready,
    output cnw_pkg::result_t  head_data
);

    cnw_pkg::result_t  slot_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_data  = slot_reg[rd_ptr_reg];
    assign pop        = head_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- hw/rtl/cpio_newc_archive_walker.sv -----
// ----------------------------------------------------------------------------
// cpio_newc_archive_walker
// Byte-wise cpio newc archive parser with one result word per input byte.
// ----------------------------------------------------------------------------
// Takes one archive byte per cycle while in_ready is high and returns one result
// word per byte, written into the output queue when the byte is taken. The parse
// state (stage, byte count, offset, decoded sizes) updates in the cycle a byte is
// accepted, so throughput is one byte per clock while the queue has room. Results
// go through a two-entry queue: in_ready drops only when both entries hold words
// that the output side has not taken, so a stalled output allows one more byte in.
// ----------------------------------------------------------------------------
module cpio_newc_archive_walker #(
    parameter int OFFSET_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        archive_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  byte_role,
    output logic        entry_ready,
    output logic [31:0] file_length,
    output logic [31:0] name_length,
    output logic [31:0] content_offset,
    output logic        is_trailer,
    output logic [1:0]  stop_cause
);

    cnw_pkg::result_t  step_result;
    cnw_pkg::result_t  head_result;
    logic              buf_full;
    logic              accept;

    assign in_ready = !buf_full;
    assign accept   = in_valid && in_ready;

    cnw_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (accept),
        .data_byte     (data_byte),
        .archive_start (archive_start),
        .result        (step_result)
    );

    cnw_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (step_result),
        .full       (buf_full),
        .head_valid (out_valid),
        .pop_ready  (out_ready),
        .head_data  (head_result)
    );

    assign byte_role      = head_result.byte_role;
    assign entry_ready    = head_result.entry_ready;
    assign file_length    = head_result.file_length;
    assign name_length    = head_result.name_length;
    assign content_offset = head_result.content_offset;
    assign is_trailer     = head_result.is_trailer;
    assign stop_cause     = head_result.stop_cause;

endmodule

// ----- hw/rtl/cnw_checker.sv -----
// ----------------------------------------------------------------------------
// cnw_checker
// Port-level checks on the result channel of the archive walker.
// ----------------------------------------------------------------------------
module cnw_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  byte_role,
    input logic        entry_ready,
    input logic [31:0] file_length,
    input logic [31:0] name_length,
    input logic [31:0] content_offset,
    input logic        is_trailer,
    input logic [1:0]  stop_cause
);

    // a held word keeps its byte role, content offset and stop cause
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(byte_role)
            && $stable(content_offset) && $stable(stop_cause))
        else $error("result word changed while stalled");

    // bytes after a stop carry no entry record
    a_ignored_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_role == cnw_pkg::ROLE_IGNORED |->
            file_length == 32'd0 && name_length == 32'd0 && content_offset == 32'd0
            && !entry_ready && !is_trailer)
        else $error("ignored byte carries entry data");

    // trailer is seen only on the word that completes the entry
    a_trailer: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_trailer |->
            entry_ready && stop_cause == cnw_pkg::STOP_TRAILER)
        else $error("trailer flag without entry completion");

    // entry completion lands on a name or name padding byte
    a_ready_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_ready |->
            byte_role == cnw_pkg::ROLE_NAME || byte_role == cnw_pkg::ROLE_NAME_PAD)
        else $error("entry completion on wrong byte role");

    // once stopped on the trailer, only the trailer word itself is parsed
    a_trailer_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && stop_cause == cnw_pkg::STOP_TRAILER
            && byte_role != cnw_pkg::ROLE_IGNORED |-> is_trailer)
        else $error("parsing continued after trailer");

endmodule

bind cpio_newc_archive_walker cnw_checker u_cnw_checker (.*);
